>>> src/opc_pkg.sv
package opc_pkg;

   localparam int DEPTH_BITS = 32;
   localparam int ALB_BITS = 16;
   localparam int ASYM_BITS = 17;
   localparam int ONE_Q15 = 32768;

   // Products of a depth and a weight, and the shifted scattering weights.
   localparam int PROD_BITS = DEPTH_BITS + 16;
   localparam int WEIGHT_SHIFT = (DEPTH_BITS > 32) ? DEPTH_BITS - 32 : 0;
   localparam int SW_BITS = PROD_BITS - WEIGHT_SHIFT;
   localparam int SDEN_BITS = SW_BITS + 1;
   // Weighted asymmetry numerator magnitude: sum of two weight*|g| products.
   localparam int NUM_BITS = SW_BITS + 17;
   localparam int DEN_BITS = DEPTH_BITS + 1;
   localparam int ADEN_BITS = (SDEN_BITS > DEN_BITS) ? SDEN_BITS : DEN_BITS;
   // One quotient bit is resolved per cell; quotients are clamped to 2^15 so
   // 17 bits (including a saturation bit) are enough.
   localparam int QBITS = 17;

   typedef enum logic [1:0] {
      MODE_DEPTH_DEPTH = 2'd0,
      MODE_DEPTH_ABS   = 2'd1,
      MODE_TS_DEPTH    = 2'd2,
      MODE_TS_TS       = 2'd3
   } mode_type;

   // Divider operands and remainders for the two quotients in flight.
   typedef struct packed {
      logic [NUM_BITS:0]  anum;
      logic [ADEN_BITS:0] aden;
      logic [QBITS-1:0]   aq;
      logic [NUM_BITS:0]  arem;
      logic [NUM_BITS:0]  wnum;
      logic [ADEN_BITS:0] wden;
      logic [QBITS-1:0]   wq;
      logic [NUM_BITS:0]  wrem;
      logic               neg;
      logic               adiv;
      logic               wdiv;
      logic [DEPTH_BITS-1:0] depth;
      logic [ALB_BITS-1:0]   alb;
      logic [ASYM_BITS-1:0]  asym;
   } div_token_type;

   typedef struct packed {
      logic          valid;
      div_token_type tok;
   } cell_bus_type;

endpackage

>>> src/opc_if.sv
interface opc_req_if;
   import opc_pkg::*;
   logic valid;
   logic ready;
   logic [DEPTH_BITS-1:0] depth_a;
   logic [ALB_BITS-1:0] albedo_a;
   logic signed [ASYM_BITS-1:0] asym_a;
   logic [DEPTH_BITS-1:0] depth_b;
   logic [ALB_BITS-1:0] albedo_b;
   logic signed [ASYM_BITS-1:0] asym_b;
   modport source (output valid, depth_a, albedo_a, asym_a, depth_b, albedo_b, asym_b,
      input ready);
   modport sink (input valid, depth_a, albedo_a, asym_a, depth_b, albedo_b, asym_b,
      output ready);
endinterface

interface opc_rsp_if;
   import opc_pkg::*;
   logic valid;
   logic ready;
   logic [DEPTH_BITS-1:0] depth_out;
   logic [ALB_BITS-1:0] albedo_out;
   logic signed [ASYM_BITS-1:0] asym_out;
   modport source (output valid, depth_out, albedo_out, asym_out, input ready);
   modport sink (input valid, depth_out, albedo_out, asym_out, output ready);
endinterface

>>> src/optical_property_combiner_top.sv
// Optical property combiner.
// Requests arrive on the req_ channel, one element of each of two
// optical-property sets; each request yields exactly one response on rsp_.
// The csr_ port writes the 2-bit combine mode (reset value 3); write it only
// while no request is in flight.
// The datapath is a pipeline: two front stages form products and weights,
// then a row of 17 division cells resolves one quotient bit each for the
// albedo and asymmetry averages, then one stage rounds and clamps.
// Throughput is one request per cycle unless the receiver stalls.
// The whole pipeline advances when its output register is empty or being
// taken, so a stalled receiver holds every stage and deasserts req_ready.
// Synchronous active-high reset empties the pipeline and sets mode 3.
module optical_property_combiner_top (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_wdata,
   opc_req_if.sink   req,
   opc_rsp_if.source rsp
);
   import opc_pkg::*;

   mode_type mode_ff;
   logic en;
   cell_bus_type bus [QBITS+1];

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TS_TS;
      end else if (csr_we) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   assign en = !rsp.valid || rsp.ready;
   assign req.ready = en;

   opc_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req.valid), .mode(mode_ff),
      .depth_a(req.depth_a), .albedo_a(req.albedo_a), .asym_a(req.asym_a),
      .depth_b(req.depth_b), .albedo_b(req.albedo_b), .asym_b(req.asym_b),
      .out_bus(bus[0])
   );

   // Row of division cells, most significant quotient bit first.
   for (genvar i = 0; i < QBITS; i++) begin : g_cell
      opc_div_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .bit_pos(5'(QBITS - 1 - i)),
         .in_bus(bus[i]), .out_bus(bus[i+1])
      );
   end

   // Round to nearest, ties away from zero, then clamp and select.
   div_token_type t;
   logic [QBITS:0] aq, wq;
   logic [ALB_BITS-1:0] alb;
   logic signed [ASYM_BITS-1:0] asy;
   logic v_ff;
   logic [DEPTH_BITS-1:0] dep_ff;
   logic [ALB_BITS-1:0] alb_ff;
   logic signed [ASYM_BITS-1:0] asy_ff;

   always_comb begin
      t = bus[QBITS].tok;
      aq = (QBITS+1)'(t.aq) + (QBITS+1)'(
         ((NUM_BITS+2)'(t.anum) << 1) >= (NUM_BITS+2)'(t.aden) && t.aden != '0);
      wq = (QBITS+1)'(t.wq) + (QBITS+1)'(
         ((NUM_BITS+2)'(t.wnum) << 1) >= (NUM_BITS+2)'(t.wden) && t.wden != '0);
      if (aq > (QBITS+1)'(ONE_Q15)) aq = (QBITS+1)'(ONE_Q15);
      if (wq > (QBITS+1)'(ONE_Q15)) wq = (QBITS+1)'(ONE_Q15);
      alb = t.wdiv ? ALB_BITS'(wq) : t.alb;
      if (!t.adiv) asy = t.asym;
      else if (t.neg) asy = -$signed(ASYM_BITS'(aq));
      else asy = $signed(ASYM_BITS'(aq));
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= bus[QBITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dep_ff <= t.depth;
         alb_ff <= alb;
         asy_ff <= asy;
      end
   end

   assign rsp.valid = v_ff;
   assign rsp.depth_out = dep_ff;
   assign rsp.albedo_out = alb_ff;
   assign rsp.asym_out = asy_ff;
endmodule

>>> src/opc_front.sv
// Input stage: clamps fields, forms the depth sums, products and weights.
// Two registered steps so that each multiplier is followed by a register.
module opc_front (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  opc_pkg::mode_type mode,
   input  logic [opc_pkg::DEPTH_BITS-1:0] depth_a,
   input  logic [opc_pkg::ALB_BITS-1:0] albedo_a,
   input  logic signed [opc_pkg::ASYM_BITS-1:0] asym_a,
   input  logic [opc_pkg::DEPTH_BITS-1:0] depth_b,
   input  logic [opc_pkg::ALB_BITS-1:0] albedo_b,
   input  logic signed [opc_pkg::ASYM_BITS-1:0] asym_b,
   output opc_pkg::cell_bus_type out_bus
);
   import opc_pkg::*;

   logic [15:0] w1, w2;
   logic signed [ASYM_BITS-1:0] g1, g2;
   logic [DEN_BITS-1:0] sum;

   // Stage one registers.
   logic v1_ff, v1_in;
   mode_type m1_ff;
   logic [PROD_BITS-1:0] p1_ff, p2_ff, pabs_ff;
   logic [DEN_BITS-1:0] sum_ff;
   logic [DEPTH_BITS-1:0] t1_ff;
   logic [15:0] w1_ff;
   logic signed [ASYM_BITS-1:0] g1_ff, g2_ff;

   // Stage two registers.
   logic v2_ff;
   mode_type m2_ff;
   logic [NUM_BITS:0] n1_ff, n2_ff;
   logic n1neg_ff, n2neg_ff;
   logic [SDEN_BITS-1:0] sden_ff;
   logic [PROD_BITS:0] wnum_ff;
   logic [DEN_BITS-1:0] sum2_ff;
   logic [DEPTH_BITS-1:0] dep2_ff;
   logic [15:0] w1b_ff;
   logic signed [ASYM_BITS-1:0] g1b_ff;

   // Asymmetry is limited to the range from minus one to plus one.
   function automatic logic signed [ASYM_BITS-1:0] clamp_g(logic signed [ASYM_BITS-1:0] g);
      if (g > $signed(ASYM_BITS'(ONE_Q15))) return $signed(ASYM_BITS'(ONE_Q15));
      if (g < -$signed(ASYM_BITS'(ONE_Q15))) return -$signed(ASYM_BITS'(ONE_Q15));
      return g;
   endfunction

   // Clamp the input fields.
   always_comb begin
      w1 = (albedo_a > 16'(ONE_Q15)) ? 16'(ONE_Q15) : albedo_a;
      w2 = (albedo_b > 16'(ONE_Q15)) ? 16'(ONE_Q15) : albedo_b;
      g1 = clamp_g(asym_a);
      g2 = clamp_g(asym_b);
      sum = DEN_BITS'(depth_a) + DEN_BITS'(depth_b);
   end

   assign v1_in = in_valid;

   // Stage one: depth-weight products.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= mode;
         p1_ff <= PROD_BITS'(depth_a) * PROD_BITS'(w1);
         p2_ff <= PROD_BITS'(depth_b) * PROD_BITS'(w2);
         pabs_ff <= PROD_BITS'(depth_b) * PROD_BITS'(17'(ONE_Q15) - 17'(w2));
         sum_ff <= sum;
         t1_ff <= depth_a;
         w1_ff <= w1;
         g1_ff <= g1;
         g2_ff <= g2;
      end
   end

   // Stage two: weights times asymmetry magnitudes, depth result.
   logic [SW_BITS-1:0] s1, s2;
   logic [16:0] ag1, ag2;
   logic [DEN_BITS:0] dsum;
   logic [DEPTH_BITS-1:0] dep;
   always_comb begin
      s1 = SW_BITS'(p1_ff >> WEIGHT_SHIFT);
      s2 = SW_BITS'(p2_ff >> WEIGHT_SHIFT);
      ag1 = g1_ff[ASYM_BITS-1] ? 17'(-g1_ff) : 17'(g1_ff);
      ag2 = g2_ff[ASYM_BITS-1] ? 17'(-g2_ff) : 17'(g2_ff);
      if (m1_ff == MODE_DEPTH_ABS)
         dsum = (DEN_BITS+1)'(t1_ff) + (DEN_BITS+1)'((pabs_ff + PROD_BITS'(16384)) >> 15);
      else
         dsum = (DEN_BITS+1)'(sum_ff);
      dep = (dsum > (DEN_BITS+1)'({DEPTH_BITS{1'b1}})) ? {DEPTH_BITS{1'b1}} :
         DEPTH_BITS'(dsum);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff <= m1_ff;
         n1_ff <= (NUM_BITS+1)'(s1) * (NUM_BITS+1)'(ag1);
         n2_ff <= (NUM_BITS+1)'(s2) * (NUM_BITS+1)'(ag2);
         n1neg_ff <= g1_ff[ASYM_BITS-1];
         n2neg_ff <= g2_ff[ASYM_BITS-1];
         sden_ff <= SDEN_BITS'(s1) + SDEN_BITS'(s2);
         wnum_ff <= (m1_ff == MODE_TS_TS) ? (PROD_BITS+1)'(p1_ff) + (PROD_BITS+1)'(p2_ff)
            : (PROD_BITS+1)'(p1_ff);
         sum2_ff <= sum_ff;
         dep2_ff <= dep;
         w1b_ff <= w1_ff;
         g1b_ff <= g1_ff;
      end
   end

   // Signed numerator combine and divider token build.
   always_comb begin
      logic [NUM_BITS+1:0] big, small_v;
      logic nneg;
      logic [NUM_BITS:0] mag;
      if (n1neg_ff == n2neg_ff) begin
         big = (NUM_BITS+2)'(n1_ff) + (NUM_BITS+2)'(n2_ff);
         nneg = n1neg_ff;
      end else if (n1_ff >= n2_ff) begin
         big = (NUM_BITS+2)'(n1_ff - n2_ff);
         nneg = n1neg_ff;
      end else begin
         big = (NUM_BITS+2)'(n2_ff - n1_ff);
         nneg = n2neg_ff;
      end
      small_v = big;
      mag = NUM_BITS'(small_v) == '0 && small_v[NUM_BITS+1:NUM_BITS] == '0 ? '0 :
         (NUM_BITS+1)'(small_v);
      out_bus.valid = v2_ff;
      out_bus.tok.anum = mag;
      out_bus.tok.aden = (ADEN_BITS+1)'(sden_ff);
      out_bus.tok.aq = '0;
      out_bus.tok.arem = '0;
      out_bus.tok.wnum = (NUM_BITS+1)'(wnum_ff);
      out_bus.tok.wden = (ADEN_BITS+1)'(sum2_ff);
      out_bus.tok.wq = '0;
      out_bus.tok.wrem = '0;
      out_bus.tok.neg = nneg && (mag != '0);
      out_bus.tok.adiv = (m2_ff == MODE_TS_TS);
      out_bus.tok.wdiv = (m2_ff == MODE_TS_TS) || (m2_ff == MODE_TS_DEPTH);
      out_bus.tok.depth = dep2_ff;
      out_bus.tok.alb = w1b_ff;
      out_bus.tok.asym = g1b_ff;
   end
endmodule

>>> src/opc_div_cell.sv
// One restoring-division cell: resolves quotient bit bit_pos of both
// quotients and hands the token to its neighbor.
module opc_div_cell (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic [4:0] bit_pos,
   input  opc_pkg::cell_bus_type in_bus,
   output opc_pkg::cell_bus_type out_bus
);
   import opc_pkg::*;

   logic valid_ff;
   div_token_type tok_ff, tok_in;

   // Compare numerator's remaining part against divisor shifted by bit_pos.
   function automatic logic step(input logic [NUM_BITS:0] num,
                                 input logic [ADEN_BITS:0] den,
                                 input logic [4:0] pos,
                                 output logic [NUM_BITS:0] rest);
      logic [NUM_BITS+QBITS+1:0] trial;
      trial = (NUM_BITS+QBITS+2)'(den) << pos;
      if (den != '0 && (NUM_BITS+QBITS+2)'(num) >= trial) begin
         rest = num - (NUM_BITS+1)'(trial);
         return 1'b1;
      end
      rest = num;
      return 1'b0;
   endfunction

   always_comb begin
      logic [NUM_BITS:0] r;
      tok_in = in_bus.tok;
      tok_in.aq[bit_pos] = step(in_bus.tok.anum, in_bus.tok.aden, bit_pos, r);
      tok_in.anum = r;
      tok_in.wq[bit_pos] = step(in_bus.tok.wnum, in_bus.tok.wden, bit_pos, r);
      tok_in.wnum = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tok_ff <= tok_in;
      end
   end

   assign out_bus.valid = valid_ff;
   assign out_bus.tok = tok_ff;
endmodule

>>> test/opc_checker.sv
module opc_checker
   import opc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [1:0] csr_wdata,
   opc_req_if.sink req,
   opc_rsp_if.sink rsp,
   output int errors,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth;
      logic [ALB_BITS-1:0] albedo;
      logic [ASYM_BITS-1:0] asym;
   } optics_type;

   mode_type mode;
   optics_type expected_optics[$];

   // Rounded division, ties away from zero; a zero divisor gives zero.
   function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
      longint unsigned q, r;
      if (d == 0) return 0;
      q = n / d;
      r = n % d;
      if (r >= d - r) q++;
      return q;
   endfunction

   function automatic longint signed asym_clamp(logic [ASYM_BITS-1:0] raw);
      longint signed v;
      v = longint'($signed(raw));
      if (v > ONE_Q15) v = ONE_Q15;
      if (v < -ONE_Q15) v = -ONE_Q15;
      return v;
   endfunction

   // Combines one element of the added set into the accumulating set.
   function automatic optics_type combine_optics(mode_type m,
         logic [DEPTH_BITS-1:0] da, logic [ALB_BITS-1:0] aa, logic [ASYM_BITS-1:0] ga,
         logic [DEPTH_BITS-1:0] db, logic [ALB_BITS-1:0] ab, logic [ASYM_BITS-1:0] gb);
      longint unsigned t1, t2, w1, w2, sum, dep, alb, p1, p2, mag, q, absd, maxd;
      longint signed g1, g2, asy, num;
      optics_type o;
      maxd = (64'd1 << DEPTH_BITS) - 1;
      t1 = da; t2 = db;
      w1 = (aa > ONE_Q15) ? ONE_Q15 : aa;
      w2 = (ab > ONE_Q15) ? ONE_Q15 : ab;
      g1 = asym_clamp(ga);
      g2 = asym_clamp(gb);
      sum = t1 + t2;
      dep = (sum > maxd) ? maxd : sum;
      alb = w1;
      asy = g1;
      case (m)
         MODE_DEPTH_ABS: begin
            absd = (t2 * (ONE_Q15 - w2) + 16384) >> 15;
            dep = (t1 + absd > maxd) ? maxd : t1 + absd;
         end
         MODE_TS_DEPTH: begin
            alb = rdiv(t1 * w1, sum);
            if (alb > ONE_Q15) alb = ONE_Q15;
         end
         MODE_TS_TS: begin
            p1 = (t1 * w1) >> WEIGHT_SHIFT;
            p2 = (t2 * w2) >> WEIGHT_SHIFT;
            num = longint'(p1) * g1 + longint'(p2) * g2;
            mag = (num < 0) ? -num : num;
            q = rdiv(mag, p1 + p2);
            if (q > ONE_Q15) q = ONE_Q15;
            asy = (num < 0) ? -longint'(q) : longint'(q);
            alb = rdiv(t1 * w1 + t2 * w2, sum);
            if (alb > ONE_Q15) alb = ONE_Q15;
         end
         default: ;
      endcase
      o.depth = dep[DEPTH_BITS-1:0];
      o.albedo = alb[ALB_BITS-1:0];
      o.asym = asy[ASYM_BITS-1:0];
      return o;
   endfunction

   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Track the mode, predict accepted requests, and compare responses.
   always @(posedge clock) begin
      optics_type want;
      if (reset) begin
         mode <= MODE_TS_TS;
         errors = 0;
         pending = 0;
      end else begin
         if (csr_we) mode <= mode_type'(csr_wdata);
         if (req.valid && req.ready)
            expected_optics.push_back(combine_optics(mode, req.depth_a, req.albedo_a,
               req.asym_a, req.depth_b, req.albedo_b, req.asym_b));
         if (rsp.valid && rsp.ready) begin
            if (expected_optics.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               want = expected_optics.pop_front();
               if (rsp.depth_out !== want.depth) report("depth", rsp.depth_out, want.depth);
               if (rsp.albedo_out !== want.albedo)
                  report("albedo", rsp.albedo_out, want.albedo);
               if (rsp.asym_out !== want.asym) report("asym", rsp.asym_out, want.asym);
            end
         end
         pending = expected_optics.size();
      end
   end
endmodule

>>> test/tb_optical_property_combiner_top.sv
module tb_optical_property_combiner_top;
   import opc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 20;
   localparam int STALL_LIMIT = 2000;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [1:0] csr_wdata = 0;
   int errors, pending, idle_cycles;

   opc_req_if req ();
   opc_rsp_if rsp ();

   optical_property_combiner_top DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.source)
   );

   opc_checker checker_i (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req.sink), .rsp(rsp.sink), .errors(errors), .pending(pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver stalls at random, with calm stretches of steady readiness.
   initial begin
      int hold;
      rsp.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         hold = gap_len();
         rsp.ready <= (hold == 0) || ($urandom_range(0, 3) == 0);
         repeat (hold + 1) @(posedge clock);
         if ($urandom_range(0, 9) == 0) begin
            rsp.ready <= 1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
      end
   end

   // Watchdog: cycles in which nothing is accepted.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic logic [ALB_BITS-1:0] pick_albedo();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return ALB_BITS'(ONE_Q15);
         2: return ALB_BITS'($urandom);
         default: return ALB_BITS'($urandom_range(0, ONE_Q15));
      endcase
   endfunction

   function automatic logic [ASYM_BITS-1:0] pick_asym();
      case ($urandom_range(0, 6))
         0: return 17'(-ONE_Q15);
         1: return 17'(ONE_Q15);
         2: return ASYM_BITS'($urandom);
         default: return 17'($signed($urandom_range(0, 2 * ONE_Q15)) - ONE_Q15);
      endcase
   endfunction

   function automatic logic [DEPTH_BITS-1:0] pick_depth();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return DEPTH_BITS'($urandom_range(0, 255));
         default: return DEPTH_BITS'($urandom);
      endcase
   endfunction

   // Presents one request and holds it until accepted.
   task automatic send_request(logic [DEPTH_BITS-1:0] da, logic [ALB_BITS-1:0] aa,
         logic [ASYM_BITS-1:0] ga, logic [DEPTH_BITS-1:0] db,
         logic [ALB_BITS-1:0] ab, logic [ASYM_BITS-1:0] gb);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.depth_a <= da; req.albedo_a <= aa; req.asym_a <= ga;
      req.depth_b <= db; req.albedo_b <= ab; req.asym_b <= gb;
      @(posedge clock iff req.ready);
   endtask

   // Drains the pipeline, then writes the mode while idle.
   task automatic set_mode(mode_type m);
      req.valid <= 0;
      @(posedge clock iff pending == 0);
      repeat (LATENCY + 2) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 0;
   endtask

   initial begin
      mode_type m;
      int w;
      req.valid = 0;
      req.depth_a = 0; req.albedo_a = 0; req.asym_a = 0;
      req.depth_b = 0; req.albedo_b = 0; req.asym_b = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed corners in every mode, starting with the reset mode.
      for (int k = 0; k < 5; k++) begin
         if (k > 0) set_mode(mode_type'(k - 1));
         send_request('0, '0, '0, '0, '0, '0);
         send_request('1, ALB_BITS'(ONE_Q15), 17'(ONE_Q15), '1, ALB_BITS'(ONE_Q15),
            17'(-ONE_Q15));
         send_request(32'h0001_0000, 16'hFFFF, 17'h1FFFF, 32'h0002_0000, 16'h8001,
            17'h10000);
         send_request(32'h10, '0, 17'h0FFFF, 32'h30, '0, 17'h10001);
         send_request(32'h8000_0000, 16'h4000, 17'h08000, 32'h8000_0000, 16'h2000,
            17'h18000);
      end

      // Random phases, the first four in modes 0 to 3 in turn and the rest in a random mode, with extremes included.
      for (int p = 0; p < 9; p++) begin
         m = (p < 4) ? mode_type'(p) : mode_type'($urandom_range(0, 3));
         set_mode(m);
         for (int n = 0; n < 50; n++)
            send_request(pick_depth(), pick_albedo(), pick_asym(),
               pick_depth(), pick_albedo(), pick_asym());
      end
      req.valid <= 0;

      w = 0;
      while (pending != 0 && w < 50000) begin
         @(posedge clock);
         w++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

>>> filelist.f
src/opc_pkg.sv
src/opc_if.sv
src/opc_front.sv
src/opc_div_cell.sv
src/optical_property_combiner_top.sv
test/opc_checker.sv
test/tb_optical_property_combiner_top.sv
